// ----- rtl/tvfu_pkg.sv -----
package tvfu_pkg;

   // frame length after reset, count byte included
   localparam logic [7:0] FRAME_BYTES_RESET = 8'd100;

   // lowest and highest valid type tag
   localparam logic [7:0] TAG_MIN = 8'd1;
   localparam logic [7:0] TAG_MAX = 8'd8;

   // payload length in bytes for each tag, zero for a tag that means nothing
   function automatic logic [3:0] payload_size(input logic [3:0] tag);
      logic [3:0] size;
      unique case (tag)
         4'd1:                   size = 4'd8;
         4'd2, 4'd3, 4'd4:       size = 4'd4;
         4'd5, 4'd6:             size = 4'd2;
         4'd7, 4'd8:             size = 4'd1;
         default:                size = 4'd0;
      endcase
      return size;
   endfunction

endpackage

// ----- rtl/typed_value_frame_unpacker.sv -----
// Typed value frame unpacker. Takes frame bytes one item per cycle on req_; the byte
// flagged by req_frame_start is the record count, and each record that follows is a tag
// (1..8) and a little-endian payload of 8, 4, 4, 4, 2, 2, 1 or 1 bytes. One rsp_ item
// comes out per completed record, with the payload zero-extended to 64 bits and
// rsp_last_record set on the record that reaches the count. Decoding stops, and bytes are
// ignored until the next frame start, when the count is reached, on an invalid tag, or
// once csr_frame_bytes bytes of the frame are taken; a partial record is dropped. A new
// item is accepted every cycle but under rsp_ backpressure, and each is held in the input
// register; a record is written to the result register as its last byte leaves. The only
// stall is backpressure on rsp_ while a result waits. Write csr_frame_bytes only idle.
module typed_value_frame_unpacker
   import tvfu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_frame_start,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_value_type,
   output logic [63:0] rsp_value_bits,
   output logic        rsp_last_record,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_frame_bytes
);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_TAG,
      PH_PAYLOAD
   } phase_type;

   logic [7:0]  frame_bytes_ff;

   logic        s1_valid_ff;
   logic [7:0]  s1_byte_ff;
   logic        s1_start_ff;

   phase_type   phase_ff,            phase_in;
   logic [7:0]  byte_position_ff,    byte_position_in;
   logic [7:0]  records_expected_ff, records_expected_in;
   logic [7:0]  records_done_ff,     records_done_in;
   logic [3:0]  current_tag_ff,      current_tag_in;
   logic [3:0]  payload_left_ff,     payload_left_in;
   logic [63:0] payload_shift_ff,    payload_shift_in;

   logic        rsp_valid_ff;
   logic [3:0]  rsp_value_type_ff;
   logic [63:0] rsp_value_bits_ff;
   logic        rsp_last_record_ff;

   logic        emit;
   logic        last;
   logic        advance;
   logic [3:0]  size;
   logic [2:0]  lane;

   // config register, always writable
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_bytes_ff <= FRAME_BYTES_RESET;
      end else if (csr_valid) begin
         frame_bytes_ff <= csr_frame_bytes;
      end
   end

   // decode of the byte in the input register
   always_comb begin
      phase_in            = phase_ff;
      byte_position_in    = byte_position_ff;
      records_expected_in = records_expected_ff;
      records_done_in     = records_done_ff;
      current_tag_in      = current_tag_ff;
      payload_left_in     = payload_left_ff;
      payload_shift_in    = payload_shift_ff;
      emit                = 1'b0;
      size                = payload_size(current_tag_ff);
      lane                = 3'(size - payload_left_ff);

      if (s1_start_ff) begin
         records_expected_in = s1_byte_ff;
         records_done_in     = 8'd0;
         byte_position_in    = 8'd1;
         current_tag_in      = 4'd0;
         payload_left_in     = 4'd0;
         payload_shift_in    = 64'd0;
         if (s1_byte_ff == 8'd0 || frame_bytes_ff <= 8'd1) begin
            phase_in = PH_IDLE;
         end else begin
            phase_in = PH_TAG;
         end
      end else if (phase_ff == PH_TAG || phase_ff == PH_PAYLOAD) begin
         if (byte_position_ff != 8'hff) begin
            byte_position_in = byte_position_ff + 8'd1;
         end
         unique case (phase_ff)
            PH_TAG: begin
               if (s1_byte_ff >= TAG_MIN && s1_byte_ff <= TAG_MAX) begin
                  current_tag_in   = s1_byte_ff[3:0];
                  payload_left_in  = payload_size(s1_byte_ff[3:0]);
                  payload_shift_in = 64'd0;
                  phase_in         = PH_PAYLOAD;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
            PH_PAYLOAD: begin
               if (payload_left_ff == 4'd0 || payload_left_ff > size) begin
                  phase_in = PH_IDLE;
               end else begin
                  payload_shift_in = payload_shift_ff
                                   | ({56'd0, s1_byte_ff} << {lane, 3'b000});
                  payload_left_in  = payload_left_ff - 4'd1;
                  if (payload_left_in == 4'd0) begin
                     records_done_in = records_done_ff + 8'd1;
                     emit            = 1'b1;
                     if (records_done_in == records_expected_ff) begin
                        phase_in = PH_IDLE;
                     end else begin
                        phase_in = PH_TAG;
                     end
                  end
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
         if (byte_position_in >= frame_bytes_ff) begin
            phase_in = PH_IDLE;
         end
      end
   end

   assign last = (records_done_in == records_expected_ff);

   // an item leaves the input register unless it ends a record while a result waits
   assign advance   = s1_valid_ff && (!emit || !rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_byte_ff  <= req_data_byte;
         s1_start_ff <= req_frame_start;
      end
   end

   // decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff            <= PH_IDLE;
         byte_position_ff    <= 8'd0;
         records_expected_ff <= 8'd0;
         records_done_ff     <= 8'd0;
         current_tag_ff      <= 4'd0;
         payload_left_ff     <= 4'd0;
         payload_shift_ff    <= 64'd0;
      end else if (advance) begin
         phase_ff            <= phase_in;
         byte_position_ff    <= byte_position_in;
         records_expected_ff <= records_expected_in;
         records_done_ff     <= records_done_in;
         current_tag_ff      <= current_tag_in;
         payload_left_ff     <= payload_left_in;
         payload_shift_ff    <= payload_shift_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_value_type_ff  <= current_tag_ff;
         rsp_value_bits_ff  <= payload_shift_in;
         rsp_last_record_ff <= last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_value_type  = rsp_value_type_ff;
   assign rsp_value_bits  = rsp_value_bits_ff;
   assign rsp_last_record = rsp_last_record_ff;

   // a completed record always lands in the result register
   assert property (@(posedge clock) disable iff (reset)
      advance && emit |=> rsp_valid_ff)
      else $error("completed record not registered");

   // payload phase always has bytes left to take
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> payload_left_ff != 4'd0)
      else $error("payload phase with nothing left");

   // an active frame has not yet reached its count
   assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_IDLE |-> records_done_ff < records_expected_ff)
      else $error("decoding past the record count");

   // input stalls only behind a waiting result
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s1_valid_ff && rsp_valid_ff)
      else $error("input stalled without a waiting result");

endmodule
